@@ sv/lfsa_pkg.sv @@
package lfsa_pkg;

  // Field widths of one transaction
  localparam int unsigned SLOT_W   = 11;
  localparam int unsigned STATUS_W = 2;

  // Highest slot number the slot fields can carry
  localparam int unsigned SLOT_MAX = (2 ** SLOT_W) - 1;

  // Leaf words of the occupancy store
  localparam int unsigned LEAF_W  = 32;
  localparam int unsigned LEAF_BW = 5;

  // Configuration port
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_SEAT_COUNT = 1'b0;
  localparam logic [SLOT_W-1:0]    SEAT_COUNT_RST = 11'd1024;

  typedef enum logic {
    FN_RESERVE = 1'b0,
    FN_RELEASE = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_e;

  typedef enum logic {
    ES_IDLE   = 1'b0,
    ES_MODIFY = 1'b1
  } engine_state_e;

endpackage

@@ sv/lfsa_leaf_ram.sv @@
module lfsa_leaf_ram
  import lfsa_pkg::*;
#(
  parameter int unsigned WORDS = 32,
  parameter int unsigned AW    = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [LEAF_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [LEAF_W-1:0] wr_data_i
);

  logic [LEAF_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  written_q;
  logic [LEAF_W-1:0] rd_data_q;
  logic              rd_written_q;

  // Leaf storage and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Per-word written flags: a word never written reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

@@ sv/lfsa_apb_regs.sv @@
module lfsa_apb_regs
  import lfsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [SLOT_W-1:0] seat_count_o
);

  logic [SLOT_W-1:0]    seat_count_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_seat_count;

  // Word-aligned register decode
  assign reg_idx       = paddr[APB_AW-1:2];
  assign wr_seat_count = psel & penable & pwrite & (reg_idx == REG_SEAT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seat_count_q <= SEAT_COUNT_RST;
    end else if (wr_seat_count) begin
      seat_count_q <= pwdata[SLOT_W-1:0];
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SEAT_COUNT) begin
      prdata = APB_DW'(seat_count_q);
    end
  end

  assign pready       = 1'b1;
  assign seat_count_o = seat_count_q;

endmodule

@@ sv/lfsa_engine.sv @@
module lfsa_engine
  import lfsa_pkg::*;
#(
  parameter int unsigned USED  = 1024,
  parameter int unsigned WORDS = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SLOT_W-1:0]   seat_count_i,
  // request side
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [SLOT_W-1:0]   seat_number_i,
  // result side
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SLOT_W-1:0]   granted_seat_o,
  output logic [STATUS_W-1:0] status_o,
  // leaf memory
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  logic [LEAF_W-1:0]   rd_data_i,
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output logic [LEAF_W-1:0]   wr_data_o
);

  localparam logic [SLOT_W-1:0] UsedSlots = SLOT_W'(USED);
  localparam int unsigned       LastRem   = USED - (WORDS - 1) * LEAF_W;
  localparam logic [LEAF_W:0]   LastOnes  = (LEAF_W+1)'((64'd1 << LastRem) - 64'd1);
  // Bits past the last slot always look taken
  localparam logic [LEAF_W-1:0] LastPad   = ~LastOnes[LEAF_W-1:0];
  localparam logic [AW-1:0]     LastWord  = AW'(WORDS - 1);

  engine_state_e state_q, state_d;

  logic [WORDS-1:0]   full_q;
  logic               func_q;
  logic [AW-1:0]      word_q;
  logic [LEAF_BW-1:0] bit_q;
  logic               skip_q;

  logic                out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]   granted_q;
  status_e             status_q;

  logic                accept;
  logic [SLOT_W-1:0]   n_active;
  logic [SLOT_W-1:0]   seat_m1;
  logic [SLOT_W-LEAF_BW-1:0] rel_word;
  logic                rel_bad;
  logic                any_free;
  logic [AW-1:0]       free_word;

  logic [LEAF_W-1:0]   pad;
  logic [LEAF_W-1:0]   cur;
  logic [LEAF_BW-1:0]  zero_bit;
  logic [SLOT_W-1:0]   cand_slot;
  logic                sum_we;
  logic                sum_full;
  logic [SLOT_W-1:0]   res_seat;
  status_e             res_status;

  // Handshake and active slot count
  assign in_stall_o = (state_q != ES_IDLE) | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;
  assign n_active   = (seat_count_i > UsedSlots) ? UsedSlots : seat_count_i;

  // Release decode
  assign seat_m1  = seat_number_i - SLOT_W'(1);
  assign rel_word = seat_m1[SLOT_W-1:LEAF_BW];
  assign rel_bad  = (seat_number_i == '0) | (seat_number_i > n_active);

  // Summary search: lowest word that still has a free bit
  always_comb begin
    any_free  = 1'b0;
    free_word = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        any_free  = 1'b1;
        free_word = AW'(i);
      end
    end
  end

  // Leaf read issued with the transaction
  assign rd_en_o   = accept;
  assign rd_addr_o = (func_i == FN_RELEASE) ? (rel_bad ? '0 : rel_word[AW-1:0]) : free_word;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ES_IDLE:   if (accept) state_d = ES_MODIFY;
      ES_MODIFY: state_d = ES_IDLE;
      default:   state_d = ES_IDLE;
    endcase
  end

  // Leaf word search: lowest free bit
  assign pad = (word_q == LastWord) ? LastPad : '0;
  assign cur = rd_data_i | pad;

  always_comb begin
    zero_bit = '0;
    for (int b = LEAF_W - 1; b >= 0; b--) begin
      if (!cur[b]) zero_bit = LEAF_BW'(b);
    end
  end

  assign cand_slot = SLOT_W'({word_q, zero_bit}) + SLOT_W'(1);

  // Modify and write back
  always_comb begin
    wr_en_o    = 1'b0;
    wr_addr_o  = word_q;
    wr_data_o  = rd_data_i;
    sum_we     = 1'b0;
    sum_full   = 1'b0;
    res_seat   = '0;
    res_status = ST_OK;
    if (state_q == ES_MODIFY) begin
      if (func_q == FN_RESERVE) begin
        if (skip_q || (cand_slot > n_active)) begin
          res_status = ST_FULL;
        end else begin
          wr_en_o   = 1'b1;
          wr_data_o = rd_data_i | (LEAF_W'(1) << zero_bit);
          sum_we    = 1'b1;
          sum_full  = &(wr_data_o | pad);
          res_seat  = cand_slot;
        end
      end else begin
        if (skip_q || !rd_data_i[bit_q]) begin
          res_status = ST_BAD_RELEASE;
        end else begin
          wr_en_o   = 1'b1;
          wr_data_o = rd_data_i & ~(LEAF_W'(1) << bit_q);
          sum_we    = 1'b1;
          sum_full  = 1'b0;
        end
      end
    end
  end

  // Result register: free again once the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ES_MODIFY) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ES_IDLE;
      out_valid_q <= 1'b0;
      full_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (sum_we) begin
        full_q[word_q] <= sum_full;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      bit_q  <= seat_m1[LEAF_BW-1:0];
      word_q <= rd_addr_o;
      skip_q <= (func_i == FN_RELEASE) ? rel_bad : ~any_free;
    end
    if (state_q == ES_MODIFY) begin
      granted_q <= res_seat;
      status_q  <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_seat_o = granted_q;
  assign status_o       = status_q;

endmodule

@@ sv/lowest_free_slot_allocator_top.sv @@
// Lowest-free slot allocator. Each request transaction either reserves the
// lowest-numbered free slot in 1..seat_count or releases a named slot, and
// gives one result transaction (granted slot, status: ok, no free slot, or
// bad release). Occupancy is a two-level bitmap: a per-word "full" summary in
// flip-flops and 32-slot leaf words in a single-port-per-direction RAM. Each
// transaction searches the summary and issues the leaf read (ES_IDLE), then
// picks the bit and writes the leaf back (ES_MODIFY). The RAM's read-modify-
// write means a new request is taken only after the previous one is done. The
// result sits in an output register while the next request is accepted, unless it is stalled.
// Slots are cleared by per-word written flags at reset, so there is no
// clearing pass. seat_count (APB offset 0) may only change while idle; counts
// above SEATS act as SEATS, and slots above 2047 are not addressable.
module lowest_free_slot_allocator_top
  import lfsa_pkg::*;
#(
  parameter int unsigned SEATS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // request
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [SLOT_W-1:0]   seat_number_i,
  // result
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SLOT_W-1:0]   granted_seat_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned Used  = (SEATS < SLOT_MAX) ? SEATS : SLOT_MAX;
  localparam int unsigned Words = (Used + LEAF_W - 1) / LEAF_W;
  localparam int unsigned Aw    = (Words > 1) ? $clog2(Words) : 1;

  logic [SLOT_W-1:0] seat_count;
  logic              rd_en;
  logic [Aw-1:0]     rd_addr;
  logic [LEAF_W-1:0] rd_data;
  logic              wr_en;
  logic [Aw-1:0]     wr_addr;
  logic [LEAF_W-1:0] wr_data;

  lfsa_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .seat_count_o (seat_count)
  );

  lfsa_engine #(
    .USED  (Used),
    .WORDS (Words),
    .AW    (Aw)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seat_count_i   (seat_count),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .seat_number_i  (seat_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_seat_o (granted_seat_o),
    .status_o       (status_o),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  lfsa_leaf_ram #(
    .WORDS (Words),
    .AW    (Aw)
  ) u_leaf_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

@@ sv/lfsa_checker.sv @@
module lfsa_checker
  import lfsa_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [SLOT_W-1:0]   granted_seat_o,
  input logic [STATUS_W-1:0] status_o
);

  // One transaction in flight: stall the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one still in flight");

  // Result is presented once the request has passed the modify state
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)
    else $error("result missing two cycles after request");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FULL ||
                     status_o == ST_BAD_RELEASE))
    else $error("undefined status code");

  // Failed requests never grant a slot
  a_no_grant_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> granted_seat_o == '0)
    else $error("slot granted alongside error status");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(granted_seat_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind lowest_free_slot_allocator_top lfsa_checker u_lfsa_checker (.*);

@@ test/slot_allocation_checker.sv @@
`timescale 1ns / 100ps

// Watches the request, result and APB channels of the slot allocator, keeps its
// own occupancy map and seat count, and compares every result transaction with
// the oldest prediction.
module slot_allocation_checker
  import lfsa_pkg::*;
#(
  parameter int unsigned SEATS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [APB_AW-1:0]   paddr_i,
  input  logic [APB_DW-1:0]   pwdata_i,
  input  logic [APB_DW-1:0]   prdata_i,
  input  logic                pready_i,
  // request channel
  input  logic                req_valid_i,
  input  logic                req_stall_i,
  input  logic                func_i,
  input  logic [SLOT_W-1:0]   seat_number_i,
  // result channel
  input  logic                res_valid_i,
  input  logic                res_stall_i,
  input  logic [SLOT_W-1:0]   granted_seat_i,
  input  logic [STATUS_W-1:0] status_i,
  // to the testbench top
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  localparam logic [APB_AW-1:0] SEAT_COUNT_ADDR = {REG_SEAT_COUNT, 2'b00};

  typedef struct packed {
    logic [SLOT_W-1:0] seat;
    status_e           status;
  } alloc_result_t;

  logic              slot_taken [1:SEATS];
  logic [SLOT_W-1:0] seat_count;
  alloc_result_t     expected_results [$];
  int unsigned       mismatches;

  // Apply one request to the occupancy map and queue the result it must give
  task automatic predict_request(input func_e fn, input logic [SLOT_W-1:0] seat);
    int unsigned   n;
    int unsigned   s;
    alloc_result_t res;
    n = (seat_count > SEATS) ? SEATS : seat_count;
    res.seat   = '0;
    res.status = ST_OK;
    if (fn == FN_RESERVE) begin
      // lowest free slot in 1..n, or none
      res.status = ST_FULL;
      for (s = 1; s <= n && res.status == ST_FULL; s++) begin
        if (!slot_taken[s]) begin
          slot_taken[s] = 1'b1;
          res.seat      = s[SLOT_W-1:0];
          res.status    = ST_OK;
        end
      end
    end else begin
      if (seat == 0 || seat > n || !slot_taken[seat]) begin
        res.status = ST_BAD_RELEASE;
      end else begin
        slot_taken[seat] = 1'b0;
      end
    end
    expected_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned   s;
    alloc_result_t want;
    if (!rst_ni) begin
      for (s = 1; s <= SEATS; s++) slot_taken[s] = 1'b0;
      seat_count = SEAT_COUNT_RST;
      expected_results.delete();
      mismatches   = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // register accesses
      if (psel_i && penable_i && pready_i && paddr_i == SEAT_COUNT_ADDR) begin
        if (pwrite_i) begin
          seat_count = pwdata_i[SLOT_W-1:0];
        end else if (prdata_i[SLOT_W-1:0] !== seat_count) begin
          $display("%0t: seat_count readback expected %0d actual %0d",
                   $time, seat_count, prdata_i[SLOT_W-1:0]);
          mismatches++;
        end
      end

      // result transaction against the oldest prediction
      if (res_valid_i && !res_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, actual seat %0d status %0d",
                   $time, granted_seat_i, status_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (granted_seat_i !== want.seat) begin
            $display("%0t: granted_seat expected %0d actual %0d",
                     $time, want.seat, granted_seat_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, status_i);
            mismatches++;
          end
        end
      end

      // request transaction
      if (req_valid_i && !req_stall_i) begin
        predict_request(func_e'(func_i), seat_number_i);
      end

      mismatches_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

@@ test/lowest_free_slot_allocator_top_tb.sv @@
`timescale 1ns / 100ps

module lowest_free_slot_allocator_top_tb;
  import lfsa_pkg::*;

  localparam int unsigned SEATS           = 1024;
  localparam int unsigned IDLE_PCT        = 14;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned HOLD_PHASE      = 5;
  localparam int unsigned PAUSE_PHASE     = 1;
  localparam logic [APB_AW-1:0] SEAT_COUNT_ADDR = {REG_SEAT_COUNT, 2'b00};

  // seat count, request count and share of reserves for each random phase
  int unsigned phase_count   [NUM_PHASES] = '{5, 40, 33, 1, 0, 1024, 1025, 100};
  int unsigned phase_items   [NUM_PHASES] = '{80, 150, 100, 40, 20, 500, 200, 110};
  int unsigned phase_reserve [NUM_PHASES] = '{60, 65, 40, 50, 50, 85, 70, 30};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                func_i        = 1'b0;
  logic [SLOT_W-1:0]   seat_number_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [SLOT_W-1:0]   granted_seat_o;
  logic [STATUS_W-1:0] status_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count  = 0;
  int unsigned active_slots = SEATS;
  int unsigned live_guess   = 0;
  bit          quiet_flow   = 1'b0;
  bit          hold_request = 1'b0;

  lowest_free_slot_allocator_top #(.SEATS(SEATS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .seat_number_i  (seat_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_seat_o (granted_seat_o),
    .status_o       (status_o)
  );

  slot_allocation_checker #(.SEATS(SEATS)) alloc_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .req_valid_i    (in_valid_i),
    .req_stall_i    (in_stall_o),
    .func_i         (func_i),
    .seat_number_i  (seat_number_i),
    .res_valid_i    (out_valid_o),
    .res_stall_i    (out_stall_i),
    .granted_seat_i (granted_seat_o),
    .status_i       (status_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (quiet_flow) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // One APB transfer: setup phase, access until pready, then idle
  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write the seat count and read it back
  task automatic write_seat_count(input int unsigned value);
    apb_access(1'b1, SEAT_COUNT_ADDR, value);
    apb_access(1'b0, SEAT_COUNT_ADDR, '0);
    active_slots = (value[SLOT_W-1:0] > SEATS) ? SEATS : value[SLOT_W-1:0];
  endtask

  // Offer one request transaction and hold it until taken; valid stays high
  task automatic send_request(input func_e fn, input logic [SLOT_W-1:0] seat);
    while (!quiet_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    seat_number_i <= seat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // rough count of taken slots, used to aim releases
    if (fn == FN_RESERVE) begin
      if (live_guess < active_slots) live_guess++;
    end else if (seat != 0 && seat <= active_slots && live_guess != 0) begin
      live_guess--;
    end
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly slots that are likely taken, some edge values and some noise
  function automatic logic [SLOT_W-1:0] pick_release_seat(input int unsigned n);
    int unsigned roll;
    int unsigned span;
    int unsigned edge_pick;
    roll = $urandom_range(0, 99);
    span = (live_guess + 2 < n) ? live_guess + 2 : n;
    if (roll < 10) return SLOT_W'($urandom_range(0, SLOT_MAX));
    if (roll < 18) begin
      edge_pick = $urandom_range(0, 2);
      if (edge_pick == 0) return '0;
      if (edge_pick == 1) return n[SLOT_W-1:0];
      edge_pick = n + 1;
      return edge_pick[SLOT_W-1:0];
    end
    if (span == 0) return '0;
    return SLOT_W'($urandom_range(1, span));
  endfunction

  initial begin : stimulus
    int unsigned       p;
    int unsigned       i;
    logic [SLOT_W-1:0] seat;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the count
    apb_access(1'b0, SEAT_COUNT_ADDR, '0);

    // full capacity: grants, good and bad releases
    send_request(FN_RESERVE, '0);
    send_request(FN_RESERVE, '0);
    send_request(FN_RESERVE, '0);
    send_request(FN_RELEASE, 11'd2);
    send_request(FN_RELEASE, 11'd2);
    send_request(FN_RELEASE, '0);
    send_request(FN_RELEASE, 11'd1024);
    send_request(FN_RELEASE, 11'd1025);
    send_request(FN_RELEASE, SLOT_W'(SLOT_MAX));
    send_request(FN_RESERVE, SLOT_W'(SLOT_MAX));
    drain_results();

    // zero count: nothing to grant or release
    write_seat_count(0);
    send_request(FN_RESERVE, '0);
    send_request(FN_RELEASE, 11'd1);
    drain_results();

    // every slot in range taken
    write_seat_count(3);
    send_request(FN_RESERVE, '0);
    send_request(FN_RELEASE, 11'd3);
    send_request(FN_RESERVE, '0);
    drain_results();

    // shrunk count keeps slot 3 taken but out of reach
    write_seat_count(2);
    send_request(FN_RELEASE, 11'd3);
    send_request(FN_RESERVE, '0);
    drain_results();

    // count above capacity acts as full capacity
    write_seat_count(SLOT_MAX);
    send_request(FN_RELEASE, 11'd3);
    send_request(FN_RESERVE, '0);
    send_request(FN_RESERVE, '0);
    send_request(FN_RELEASE, 11'd1024);
    send_request(FN_RELEASE, 11'd1);
    send_request(FN_RESERVE, '0);
    drain_results();
    live_guess = 4;

    // random phases across several counts
    for (p = 0; p < NUM_PHASES; p++) begin
      write_seat_count(phase_count[p]);
      for (i = 0; i < phase_items[p]; i++) begin
        if (p == HOLD_PHASE && i == 40) hold_request = 1'b1;
        quiet_flow = (p == HOLD_PHASE && i >= 200 && i < 400);
        if (p == PAUSE_PHASE && i == 75) drain_results();
        if ($urandom_range(0, 99) < phase_reserve[p]) begin
          seat = SLOT_W'($urandom_range(0, SLOT_MAX));
          send_request(FN_RESERVE, seat);
        end else begin
          send_request(FN_RELEASE, pick_release_seat(active_slots));
        end
      end
      quiet_flow = 1'b0;
      drain_results();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
